// ===== design/crsp_pkg.sv =====
// Shared types, constants and saturating helpers for the response spectrum peak unit.
`timescale 1ns / 1ps

package crsp_pkg;

    // Datapath word of the shared units
    localparam int WORD_W = 64;
    localparam int SH_W = 6;
    localparam int FRAC = 40;
    // Sample fixed point is aligned to this many bits before use
    localparam int AG_POINT = 48;
    // Divider runs 64 integer bits plus 40 fraction bits
    localparam int DIV_STEPS = WORD_W + FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int STATE_WIDTH_DEF = 48;

    // Configuration registers
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;
    localparam int FREQ_W = 24;
    localparam int DAMP_W = 16;
    localparam int STEP_W = 24;
    localparam logic [FREQ_W-1:0] FREQ_RST = 24'd16384;
    localparam logic [DAMP_W-1:0] DAMP_RST = 16'd3277;
    localparam logic [STEP_W-1:0] STEP_RST = 24'd83886;

    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] ONE_Q40 = 64'sd1 <<< FRAC;
    // 2*pi rounded to Q.40
    localparam logic signed [WORD_W-1:0] TWO_PI =
        ((64'sd6283186 <<< FRAC) + 64'sd500000) / 64'sd1000000;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic [SH_W-1:0]          sh;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [WORD_W-1:0] sadd(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            sadd = s[WORD_W] ? WMIN : WMAX;
        end else begin
            sadd = s[WORD_W-1:0];
        end
    endfunction

    function automatic logic signed [WORD_W-1:0] sneg(input logic signed [WORD_W-1:0] a);
        sneg = (a == WMIN) ? WMAX : -a;
    endfunction

    function automatic logic [WORD_W-1:0] uabs(input logic signed [WORD_W-1:0] a);
        uabs = a[WORD_W-1] ? (WORD_W'(0) - WORD_W'(a)) : WORD_W'(a);
    endfunction

endpackage

// ===== design/crsp_mul.sv =====
// Shared rounding, saturating fixed-point multiplier built from 32x32 partial products.
`timescale 1ns / 1ps

module crsp_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  crsp_pkg::mul_req_t  req,
    output crsp_pkg::mul_rsp_t  rsp
);

    localparam int W = crsp_pkg::WORD_W;
    localparam int HW = W / 2;

    typedef enum logic [1:0] {M_IDLE, M_PROD, M_RND, M_SHF} mstate_t;

    mstate_t                   mstate_reg;
    logic [2:0]                cnt_reg;
    logic                      neg_reg;
    logic [W-1:0]              ua_reg;
    logic [W-1:0]              ub_reg;
    logic [crsp_pkg::SH_W-1:0] sh_reg;
    logic [W-1:0]              prod_reg;
    logic [1:0]                sft_reg;
    logic [2*W-1:0]            acc_reg;
    logic                      done_reg;
    logic signed [W-1:0]       res_reg;

    logic [HW-1:0]  a_part;
    logic [HW-1:0]  b_part;
    logic [W-1:0]   part_prod;
    logic [1:0]     part_sft;
    logic [2*W-1:0] part_shifted;
    logic [2*W-1:0] rnd;
    logic [2*W-1:0] shifted;
    logic [W-1:0]   mag;

    // partial product select and alignment
    always_comb begin
        a_part = cnt_reg[0] ? ua_reg[W-1:HW] : ua_reg[HW-1:0];
        b_part = cnt_reg[1] ? ub_reg[W-1:HW] : ub_reg[HW-1:0];
        part_prod = a_part * b_part;
        part_sft = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
        part_shifted = {{W{1'b0}}, prod_reg} << {sft_reg, 5'b0};
        rnd = {{(2*W-1){1'b0}}, 1'b1} << (sh_reg - 6'd1);
        shifted = acc_reg >> sh_reg;
        mag = (|shifted[2*W-1:W-1]) ? W'(crsp_pkg::WMAX) : {1'b0, shifted[W-2:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mstate_reg <= M_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            case (mstate_reg)
                M_IDLE: begin
                    if (req.start) begin
                        neg_reg <= req.a[W-1] ^ req.b[W-1];
                        ua_reg <= crsp_pkg::uabs(req.a);
                        ub_reg <= crsp_pkg::uabs(req.b);
                        sh_reg <= req.sh;
                        acc_reg <= '0;
                        cnt_reg <= 3'd0;
                        mstate_reg <= M_PROD;
                    end
                end
                M_PROD: begin
                    // product of this pass, sum of the previous one
                    if (cnt_reg != 3'd4) begin
                        prod_reg <= part_prod;
                        sft_reg <= part_sft;
                    end
                    if (cnt_reg != 3'd0) begin
                        acc_reg <= acc_reg + part_shifted;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4) begin
                        mstate_reg <= M_RND;
                    end
                end
                M_RND: begin
                    acc_reg <= acc_reg + rnd;
                    mstate_reg <= M_SHF;
                end
                M_SHF: begin
                    res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
                    done_reg <= 1'b1;
                    mstate_reg <= M_IDLE;
                end
                default: mstate_reg <= M_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = res_reg;

endmodule

// ===== design/crsp_div.sv =====
// Shared restoring divider, one quotient bit per cycle, Q.40 result saturated.
`timescale 1ns / 1ps

module crsp_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  crsp_pkg::div_req_t  req,
    output crsp_pkg::div_rsp_t  rsp
);

    localparam int W = crsp_pkg::WORD_W;
    localparam int CW = crsp_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(crsp_pkg::DIV_STEPS - 1);

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [W-1:0]        num_reg;
    logic [W-1:0]        den_reg;
    logic [W-1:0]        rem_reg;
    logic [W-1:0]        quot_reg;
    logic                sticky_reg;
    logic                done_reg;
    logic signed [W-1:0] res_reg;

    logic [W-1:0] rem_shift;
    logic         ge;

    // remainder stays below the divisor, so one shift never overflows
    always_comb begin
        rem_shift = {rem_reg[W-2:0], num_reg[W-1]};
        ge = (rem_shift >= den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    num_reg <= req.num;
                    den_reg <= req.den;
                    rem_reg <= '0;
                    quot_reg <= '0;
                    sticky_reg <= 1'b0;
                    cnt_reg <= '0;
                    busy_reg <= 1'b1;
                end
            end else begin
                rem_reg <= ge ? (rem_shift - den_reg) : rem_shift;
                num_reg <= {num_reg[W-2:0], 1'b0};
                quot_reg <= {quot_reg[W-2:0], ge};
                sticky_reg <= sticky_reg | quot_reg[W-1];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    // any quotient bit at or above the sign position saturates
                    res_reg <= (sticky_reg | quot_reg[W-1] | quot_reg[W-2]) ?
                               crsp_pkg::WMAX : $signed({quot_reg[W-2:0], ge});
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = res_reg;

endmodule

// ===== design/sdof_response_spectrum_peak_unit.sv =====
// Top level: sequencer, state and coefficient registers of the response spectrum peak unit.
// Usage:
// Ground-acceleration words enter on the s_ stream (s_tdata holds the signed sample,
// s_tlast marks the last sample of a record). One word is taken at a time; s_tready
// is high only while the sequencer is idle. Each word runs eight multiplies through
// one shared multiplier. The first sample of a record first derives the step
// coefficients from the config registers: nine multiplies plus four divides on a
// bit-serial divider. A last sample adds two multiplies and then loads the result
// word: peak displacement, pseudo-velocity and pseudo-acceleration, lowest bits
// first. The result register holds the word until m_tready takes it; a further
// result waits in the sequencer while it is full, and new samples are refused
// meanwhile. Registers are written by cfg_wr_en; the first word of a record reads
// them while it derives the coefficients, so the user must write them only while no
// word is in flight; the block itself does not enforce this. They take effect from
// the next record on. Reset (aresetn low, synchronous) returns config to its
// defaults, clears state and starts a new record.
`timescale 1ns / 1ps

module sdof_response_spectrum_peak_unit #(
    parameter int SAMPLE_WIDTH = crsp_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH = crsp_pkg::STATE_WIDTH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // ground_accel
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic                                      s_tlast,
    // peak_disp, pseudo_vel, pseudo_accel
    output logic [((3*(STATE_WIDTH-1)+7)/8)*8-1:0]    m_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic                                      cfg_wr_en,
    input  logic [crsp_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [crsp_pkg::CFG_DATA_W-1:0]           cfg_wr_data
);

    localparam int W = crsp_pkg::WORD_W;
    localparam int SW = STATE_WIDTH;
    localparam int OW = STATE_WIDTH - 1;
    localparam int ODW = ((3*OW+7)/8)*8;
    localparam logic signed [W-1:0] SMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [W-1:0] SMIN = -SMAX - 64'sd1;
    localparam logic [SW-1:0] OMAX = {1'b0, {(SW-1){1'b1}}};

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_PUSH} state_t;
    typedef enum logic [4:0] {
        OP_W, OP_OD, OP_W2, OP_DT2, OP_ODDT, OP_KD, OP_N2, OP_N3, OP_E,
        OP_C1, OP_C2, OP_C3, OP_G,
        OP_S1, OP_S2, OP_S3, OP_S4, OP_S5, OP_S6, OP_S7, OP_S8,
        OP_PV, OP_PA
    } op_t;

    function automatic logic signed [SW-1:0] sat_st(input logic signed [W-1:0] v);
        if (v > SMAX) begin
            sat_st = SMAX[SW-1:0];
        end else if (v < SMIN) begin
            sat_st = SMIN[SW-1:0];
        end else begin
            sat_st = v[SW-1:0];
        end
    endfunction

    function automatic logic [OW-1:0] clamp_out(input logic signed [W-1:0] v);
        clamp_out = ($unsigned(v) > W'(OMAX)) ? OMAX[OW-1:0] : v[OW-1:0];
    endfunction

    state_t state_reg;
    op_t    op_reg;

    // configuration
    logic [crsp_pkg::FREQ_W-1:0] freq_reg;
    logic [crsp_pkg::DAMP_W-1:0] damp_reg;
    logic [crsp_pkg::STEP_W-1:0] step_reg;

    // record state
    logic signed [SW-1:0] disp_reg;
    logic signed [SW-1:0] vel_reg;
    logic signed [SW-1:0] acc_reg;
    logic [SW-1:0]        peak_reg;
    logic                 start_reg;
    logic signed [SAMPLE_WIDTH-1:0] ag_reg;
    logic                 last_reg;

    // step coefficients
    logic signed [W-1:0] c1_reg, c2_reg, c3_reg, g_reg, h_reg, w_reg, w2_reg, e_reg;

    // derivation and step temporaries
    logic signed [W-1:0] od_reg, dt2_reg, dsum_reg, kd_reg, n2_reg, n3_reg;
    logic signed [W-1:0] t_reg, u_reg;
    logic signed [SW-1:0] d2_reg, a2_reg;

    logic                  m_tvalid_reg;
    logic [ODW-1:0]        m_tdata_reg;

    crsp_pkg::mul_req_t mul_req;
    crsp_pkg::mul_rsp_t mul_rsp;
    crsp_pkg::div_req_t div_req;
    crsp_pkg::div_rsp_t div_rsp;

    logic                op_is_div;
    logic                unit_done;
    logic signed [W-1:0] ag;
    logic signed [W-1:0] f64, xi64, dt64;
    logic signed [W-1:0] disp64, vel64, acc64, d264, a264;
    logic signed [W-1:0] p;
    logic [SW-1:0]       d2_mag;
    logic                push_ok;

    crsp_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));
    crsp_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // widened operands
    always_comb begin
        ag = W'(ag_reg) <<< (crsp_pkg::AG_POINT - SAMPLE_WIDTH);
        f64 = $signed(W'(freq_reg) << 26);
        xi64 = $signed(W'(damp_reg) << 24);
        dt64 = $signed(W'(step_reg) << 16);
        disp64 = W'(disp_reg);
        vel64 = W'(vel_reg);
        acc64 = W'(acc_reg);
        d264 = W'(d2_reg);
        a264 = W'(a2_reg);
        p = mul_rsp.prod;
        d2_mag = d2_reg[SW-1] ? (SW'(0) - $unsigned(d2_reg)) : $unsigned(d2_reg);
        op_is_div = op_reg inside {OP_C1, OP_C2, OP_C3, OP_G};
        unit_done = op_is_div ? div_rsp.done : mul_rsp.done;
        push_ok = !m_tvalid_reg || m_tready;
    end

    // operand select for the shared units
    always_comb begin
        mul_req.start = (state_reg == ST_ISSUE) && !op_is_div;
        div_req.start = (state_reg == ST_ISSUE) && op_is_div;
        mul_req.a = '0;
        mul_req.b = '0;
        mul_req.sh = 6'd40;
        div_req.num = '0;
        div_req.den = '0;
        case (op_reg)
            OP_W:    begin mul_req.a = crsp_pkg::TWO_PI; mul_req.b = f64; end
            OP_OD:   begin mul_req.a = w_reg; mul_req.b = xi64; end
            OP_W2:   begin mul_req.a = w_reg; mul_req.b = w_reg; mul_req.sh = 6'd56; end
            OP_DT2:  begin mul_req.a = dt64; mul_req.b = dt64; end
            OP_ODDT: begin mul_req.a = od_reg; mul_req.b = dt64; end
            OP_KD:   begin mul_req.a = w2_reg; mul_req.b = dt2_reg; mul_req.sh = 6'd26; end
            OP_N2:   begin mul_req.a = od_reg; mul_req.b = dt2_reg; mul_req.sh = 6'd41; end
            OP_N3:   begin mul_req.a = dt64; mul_req.b = dt64; mul_req.sh = 6'd42; end
            OP_E:    begin mul_req.a = w_reg; mul_req.b = xi64; mul_req.sh = 6'd55; end
            OP_C1:   begin div_req.num = dsum_reg; div_req.den = kd_reg; end
            OP_C2:   begin div_req.num = n2_reg; div_req.den = kd_reg; end
            OP_C3:   begin div_req.num = n3_reg; div_req.den = kd_reg; end
            OP_G:    begin div_req.num = crsp_pkg::ONE_Q40; div_req.den = dsum_reg; end
            OP_S1:   begin mul_req.a = c1_reg; mul_req.b = disp64; end
            OP_S2:   begin mul_req.a = c2_reg; mul_req.b = vel64; end
            OP_S3: begin
                mul_req.a = c3_reg;
                mul_req.b = crsp_pkg::sadd(acc64, crsp_pkg::sneg(ag));
            end
            OP_S4:   begin mul_req.a = h_reg; mul_req.b = acc64; end
            OP_S5:   begin mul_req.a = e_reg; mul_req.b = t_reg; mul_req.sh = 6'd24; end
            OP_S6:   begin mul_req.a = w2_reg; mul_req.b = d264; mul_req.sh = 6'd24; end
            OP_S7:   begin mul_req.a = g_reg; mul_req.b = t_reg; end
            OP_S8:   begin mul_req.a = h_reg; mul_req.b = crsp_pkg::sadd(acc64, a264); end
            OP_PV:   begin mul_req.a = d264; mul_req.b = w_reg; end
            OP_PA:   begin mul_req.a = d264; mul_req.b = w2_reg; mul_req.sh = 6'd24; end
            default: mul_req.a = '0;
        endcase
    end

    // sequencer, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_W;
            freq_reg <= crsp_pkg::FREQ_RST;
            damp_reg <= crsp_pkg::DAMP_RST;
            step_reg <= crsp_pkg::STEP_RST;
            disp_reg <= '0;
            vel_reg <= '0;
            acc_reg <= '0;
            peak_reg <= '0;
            start_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            // while pushing, the push itself reloads the word
            if (m_tvalid_reg && m_tready && (state_reg != ST_PUSH)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    crsp_pkg::CFG_FREQ: freq_reg <= cfg_wr_data[crsp_pkg::FREQ_W-1:0];
                    crsp_pkg::CFG_DAMP: damp_reg <= cfg_wr_data[crsp_pkg::DAMP_W-1:0];
                    crsp_pkg::CFG_STEP: step_reg <= cfg_wr_data[crsp_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ag_reg <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
                        last_reg <= s_tlast;
                        state_reg <= ST_ISSUE;
                        if (start_reg) begin
                            // new record: derive coefficients first
                            acc_reg <= sat_st(crsp_pkg::sneg(
                                W'($signed(s_tdata[SAMPLE_WIDTH-1:0]))
                                <<< (crsp_pkg::AG_POINT - SAMPLE_WIDTH)));
                            disp_reg <= '0;
                            vel_reg <= '0;
                            peak_reg <= '0;
                            start_reg <= 1'b0;
                            h_reg <= $signed(W'(step_reg) << 15);
                            op_reg <= OP_W;
                        end else begin
                            op_reg <= OP_S1;
                        end
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (unit_done) begin
                        state_reg <= ST_ISSUE;
                        op_reg <= op_t'(op_reg + 5'd1);
                        case (op_reg)
                            OP_W:    w_reg <= p;
                            OP_OD:   od_reg <= p;
                            OP_W2:   w2_reg <= p;
                            OP_DT2:  dt2_reg <= p;
                            OP_ODDT: dsum_reg <= crsp_pkg::sadd(crsp_pkg::ONE_Q40, p);
                            OP_KD:   kd_reg <= crsp_pkg::sadd(dsum_reg, p);
                            OP_N2:   n2_reg <= crsp_pkg::sadd(dt64, p);
                            OP_N3:   n3_reg <= p;
                            OP_E:    e_reg <= p;
                            OP_C1:   c1_reg <= div_rsp.quot;
                            OP_C2:   c2_reg <= div_rsp.quot;
                            OP_C3:   c3_reg <= div_rsp.quot;
                            OP_G:    g_reg <= div_rsp.quot;
                            OP_S1:   t_reg <= p;
                            OP_S2:   t_reg <= crsp_pkg::sadd(t_reg, p);
                            OP_S3:   d2_reg <= sat_st(crsp_pkg::sadd(t_reg, p));
                            OP_S4:   t_reg <= crsp_pkg::sadd(vel64, p);
                            OP_S5:   u_reg <= p;
                            OP_S6:   t_reg <= crsp_pkg::sadd(crsp_pkg::sadd(ag, p), u_reg);
                            OP_S7:   a2_reg <= sat_st(crsp_pkg::sneg(p));
                            OP_S8: begin
                                // commit the step and track the peak
                                vel_reg <= sat_st(crsp_pkg::sadd(vel64, p));
                                disp_reg <= d2_reg;
                                acc_reg <= a2_reg;
                                if (d2_mag > peak_reg) begin
                                    d2_reg <= (d2_mag > OMAX) ? $signed(OMAX) : $signed(d2_mag);
                                    peak_reg <= d2_mag;
                                end else begin
                                    d2_reg <= (peak_reg > OMAX) ? $signed(OMAX)
                                                                : $signed(peak_reg);
                                end
                                if (!last_reg) begin
                                    state_reg <= ST_IDLE;
                                end
                            end
                            OP_PV:   u_reg <= p;
                            OP_PA: begin
                                t_reg <= p;
                                state_reg <= ST_PUSH;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_PUSH: begin
                    if (push_ok) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= ODW'({clamp_out(t_reg), clamp_out(u_reg),
                                             d2_reg[OW-1:0]});
                        disp_reg <= '0;
                        vel_reg <= '0;
                        acc_reg <= '0;
                        peak_reg <= '0;
                        start_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    // unit results arrive only while the sequencer waits on that unit
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_WAIT) && !op_is_div)
        else $error("multiplier result outside its wait");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_WAIT) && op_is_div)
        else $error("divider result outside its wait");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mul_rsp.done && !div_rsp.done)
        else $error("unit busy while ready for a word");

    a_record_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) && push_ok |=> start_reg && (peak_reg == '0) && m_tvalid)
        else $error("record not cleared after result");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the response spectrum peak unit: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int OUT_W = 47;
    localparam logic [crsp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint SMAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ST_MAX = (64'sd1 <<< 47) - 1;
    localparam longint ST_MIN = -(64'sd1 <<< 47);
    localparam longint ONE40 = 64'sd1 <<< 40;
    localparam logic [63:0] OUT_MAX = (64'd1 << OUT_W) - 1;
    // coefficient slots
    localparam int K_C1 = 0, K_C2 = 1, K_C3 = 2, K_G = 3, K_H = 4, K_W = 5, K_W2 = 6, K_E = 7;
    localparam int DRAIN_CYCLES = 800;

    typedef struct {
        logic signed [31:0] accel;
        logic               last;
    } sample_t;

    typedef struct {
        logic [OUT_W-1:0] peak;
        logic [OUT_W-1:0] pvel;
        logic [OUT_W-1:0] pacc;
    } spectrum_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [31:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic s_tlast = 1'b0;
    logic [143:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [crsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [crsp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    sdof_response_spectrum_peak_unit dut (.*);

    always #10 aclk = ~aclk;

    // shadow registers and oscillator state
    logic [crsp_pkg::FREQ_W-1:0] freq_q = crsp_pkg::FREQ_RST;
    logic [crsp_pkg::DAMP_W-1:0] damp_q = crsp_pkg::DAMP_RST;
    logic [crsp_pkg::STEP_W-1:0] step_q = crsp_pkg::STEP_RST;
    longint disp_q = 0, vel_q = 0, acc_q = 0;
    longint unsigned peak_q = 0;
    bit new_record = 1'b1;
    longint coef[8];

    sample_t pending_words[$];
    spectrum_t spectra_due[$];
    int errors = 0;
    int words_in = 0;

    // round(a*b / 2^sh), half away from zero, saturated
    function automatic longint mul_rnd(longint a, longint b, int sh);
        logic [63:0] ua, ub;
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 64'd0 - 64'(a) : 64'(a);
        ub = b < 0 ? 64'd0 - 64'(b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'(SMAX64)) return neg ? -SMAX64 : SMAX64;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        if (b > 0 && a > SMAX64 - b) return SMAX64;
        if (b < 0 && a < -SMAX64 - 1 - b) return -SMAX64 - 1;
        return a + b;
    endfunction

    function automatic longint neg_sat(longint a);
        return (a == -SMAX64 - 1) ? SMAX64 : -a;
    endfunction

    function automatic longint clamp_state(longint v);
        if (v > ST_MAX) return ST_MAX;
        if (v < ST_MIN) return ST_MIN;
        return v;
    endfunction

    // floor(n * 2^fb / d), saturated
    function automatic longint div_frac(logic [63:0] n, logic [63:0] d, int fb);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        for (int i = 0; i < fb; i++) begin
            if (q >= (64'd1 << 62)) return SMAX64;
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    function automatic void latch_step_coeffs();
        longint two_pi, f, xi, dt, w, od, w2, dt2, dsum, kd, n2, n3;
        two_pi = longint'(((64'd6283186 << 40) + 64'd500000) / 64'd1000000);
        f = longint'(freq_q) <<< 26;
        xi = longint'(damp_q) <<< 24;
        dt = longint'(step_q) <<< 16;
        w = mul_rnd(two_pi, f, 40);
        od = mul_rnd(w, xi, 40);
        w2 = mul_rnd(w, w, 56);
        dt2 = mul_rnd(dt, dt, 40);
        dsum = add_sat(ONE40, mul_rnd(od, dt, 40));
        kd = add_sat(dsum, mul_rnd(w2, dt2, 26));
        n2 = add_sat(dt, mul_rnd(od, dt2, 41));
        n3 = mul_rnd(dt, dt, 42);
        coef[K_C1] = div_frac(dsum, kd, 40);
        coef[K_C2] = div_frac(n2, kd, 40);
        coef[K_C3] = div_frac(n3, kd, 40);
        coef[K_G] = div_frac(ONE40, dsum, 40);
        coef[K_H] = dt / 2;
        coef[K_W] = w;
        coef[K_W2] = w2;
        coef[K_E] = mul_rnd(w, xi, 55);
    endfunction

    // one Newmark step; queues the spectrum point on the last word of a record
    function automatic void step_oscillator(sample_t smp);
        longint ag, t, u, s, d2, a2, v2, pv, pa;
        logic [63:0] mag, pd;
        spectrum_t sp;
        ag = longint'(smp.accel) <<< 16;
        if (new_record) begin
            latch_step_coeffs();
            disp_q = 0;
            vel_q = 0;
            acc_q = clamp_state(neg_sat(ag));
            peak_q = 0;
            new_record = 1'b0;
        end
        t = add_sat(mul_rnd(coef[K_C1], disp_q, 40), mul_rnd(coef[K_C2], vel_q, 40));
        t = add_sat(t, mul_rnd(coef[K_C3], add_sat(acc_q, neg_sat(ag)), 40));
        d2 = clamp_state(t);
        u = mul_rnd(coef[K_E], add_sat(vel_q, mul_rnd(coef[K_H], acc_q, 40)), 24);
        s = add_sat(add_sat(ag, mul_rnd(coef[K_W2], d2, 24)), u);
        a2 = clamp_state(neg_sat(mul_rnd(coef[K_G], s, 40)));
        v2 = clamp_state(add_sat(vel_q, mul_rnd(coef[K_H], add_sat(acc_q, a2), 40)));
        disp_q = d2;
        vel_q = v2;
        acc_q = a2;
        mag = d2 < 0 ? 64'd0 - 64'(d2) : 64'(d2);
        if (mag > peak_q) peak_q = mag;
        if (!smp.last) return;
        pd = peak_q > OUT_MAX ? OUT_MAX : peak_q;
        pv = mul_rnd(longint'(pd), coef[K_W], 40);
        pa = mul_rnd(longint'(pd), coef[K_W2], 24);
        sp.peak = pd[OUT_W-1:0];
        sp.pvel = 64'(pv) > OUT_MAX ? OUT_MAX[OUT_W-1:0] : pv[OUT_W-1:0];
        sp.pacc = 64'(pa) > OUT_MAX ? OUT_MAX[OUT_W-1:0] : pa[OUT_W-1:0];
        spectra_due.insert(spectra_due.size(), sp);
        disp_q = 0;
        vel_q = 0;
        acc_q = 0;
        peak_q = 0;
        new_record = 1'b1;
    endfunction

    // sender: bursts of words with random gaps
    sample_t cur_word, nxt_word;
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_oscillator(cur_word);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    nxt_word = pending_words.pop_front();
                    cur_word <= nxt_word;
                    s_tdata <= nxt_word.accel;
                    s_tlast <= nxt_word.last;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic [7:0] pat_cnt = '0;
    int pat_mode = 0;
    spectrum_t got;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (spectra_due.size() == 0) begin
                    $error("unexpected result word: %h", m_tdata);
                    errors++;
                end else begin
                    got = spectra_due.pop_front();
                    if (m_tdata[46:0] !== got.peak) begin
                        $error("peak_disp: expected %h, actual %h", got.peak, m_tdata[46:0]);
                        errors++;
                    end
                    if (m_tdata[93:47] !== got.pvel) begin
                        $error("pseudo_vel: expected %h, actual %h", got.pvel, m_tdata[93:47]);
                        errors++;
                    end
                    if (m_tdata[140:94] !== got.pacc) begin
                        $error("pseudo_accel: expected %h, actual %h", got.pacc,
                               m_tdata[140:94]);
                        errors++;
                    end
                end
            end
            pat_cnt <= pat_cnt + 8'd1;
            if (pat_cnt == 8'd0) pat_mode <= $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && words_in >= 500) begin
                hold_done <= 1'b1;
                hold_left <= 6000;
                m_tready <= 1'b0;
            end else if (pat_mode == 0) begin
                m_tready <= 1'b1;
            end else if (pat_mode == 1) begin
                m_tready <= 1'($urandom_range(0, 1));
            end else begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        end
    end

    task automatic cfg_write(logic [crsp_pkg::CFG_IDX_W-1:0] idx,
                             logic [crsp_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            crsp_pkg::CFG_FREQ: freq_q = val;
            crsp_pkg::CFG_DAMP: damp_q = val[crsp_pkg::DAMP_W-1:0];
            crsp_pkg::CFG_STEP: step_q = val;
            default: ;
        endcase
    endtask

    task automatic cfg_set(logic [23:0] f, logic [15:0] xi, logic [23:0] dt);
        cfg_write(crsp_pkg::CFG_FREQ, f);
        cfg_write(crsp_pkg::CFG_DAMP, {8'd0, xi});
        cfg_write(crsp_pkg::CFG_STEP, dt);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // all words sent and finished, all results taken, checked after the edge settles
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_words.size() > 0 || s_tvalid || spectra_due.size() > 0 ||
                   !s_tready);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_accel();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    task automatic queue_word(logic signed [31:0] a, logic lst);
        sample_t w;
        w.accel = a;
        w.last = lst;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic queue_record(int len);
        for (int i = 0; i < len; i++) queue_word(rand_accel(), i == len - 1);
    endtask

    task automatic random_phase(int n_words, bit leave_open);
        int len;
        while (n_words > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            if (len > n_words) len = n_words;
            queue_record(len);
            n_words -= len;
        end
        if (leave_open) begin
            repeat ($urandom_range(1, 5)) queue_word(rand_accel(), 1'b0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, field extremes, single-sample records
        queue_word(32'sh7FFF_FFFF, 1'b1);
        queue_word(32'sh8000_0000, 1'b1);
        queue_word(32'sh0000_0000, 1'b1);
        queue_word(32'sh0100_0000, 1'b0);
        queue_word(32'shFF00_0000, 1'b0);
        queue_word(32'sh0000_0001, 1'b0);
        queue_word(32'shFFFF_FFFF, 1'b1);
        for (int i = 0; i < 6; i++) queue_word(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF, i == 5);
        // record left open across a register write
        queue_word(32'sh0080_0000, 1'b0);
        queue_word(32'shFF80_0000, 1'b0);
        wait_idle();

        cfg_write(CFG_UNUSED, 24'hFFFFFF);
        cfg_set(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
        queue_word(32'sh0100_0000, 1'b1);
        queue_word(32'sh7FFF_FFFF, 1'b0);
        queue_word(32'sh8000_0000, 1'b1);
        wait_idle();

        // zero time step
        cfg_set(24'd16384, 16'd3277, 24'd0);
        queue_word(32'sh0100_0000, 1'b0);
        queue_word(32'sh8000_0000, 1'b1);
        wait_idle();

        cfg_set(24'd0, 16'd0, 24'd1);
        queue_word(32'sh7FFF_FFFF, 1'b0);
        queue_word(32'sh8000_0000, 1'b1);
        wait_idle();

        // random phases over a sweep of settings, extremes included
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: cfg_set(crsp_pkg::FREQ_RST, crsp_pkg::DAMP_RST, crsp_pkg::STEP_RST);
                1: cfg_set(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
                2: cfg_set(24'd0, 16'd0, 24'd1);
                3: cfg_set(24'($urandom_range(1, 24'hFFFFFF)), 16'hFFFF, 24'd1);
                default: cfg_set(24'($urandom_range(0, 24'hFFFFFF)),
                                 16'($urandom_range(0, 16'hFFFF)),
                                 24'(($urandom_range(0, 1) ? $urandom_range(1, 24'h3FFFF)
                                                           : $urandom_range(0, 24'hFFFFFF))));
            endcase
            random_phase(145, ph % 3 == 1);
            wait_idle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
design/crsp_pkg.sv
design/crsp_mul.sv
design/crsp_div.sv
design/sdof_response_spectrum_peak_unit.sv
tb/sv/tb_top.sv
